// ===== design/tlc_pkg.sv =====
`default_nettype none
package tlc_pkg;

  localparam int CoordBits = 13;
  localparam int EndW      = 13;
  localparam int CmpW      = (CoordBits + 1 > EndW) ? CoordBits + 1 : EndW;
  localparam int PosW      = 13;
  localparam int CodeW     = 16;
  localparam int SizeW     = 8;
  localparam int OrgW      = 12;
  localparam int ScrW      = 13;
  localparam int KindW     = 3;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 13;

  localparam logic [CodeW-1:0] ChEnd = 16'd0;
  localparam logic [CodeW-1:0] ChLf  = 16'd10;
  localparam logic [CodeW-1:0] ChCr  = 16'd13;
  localparam logic [SizeW-1:0] BadBox = 8'd32;

  localparam logic [KindW-1:0] KindPlace   = 3'd0;
  localparam logic [KindW-1:0] KindInvalid = 3'd1;
  localparam logic [KindW-1:0] KindControl = 3'd2;
  localparam logic [KindW-1:0] KindClipped = 3'd3;
  localparam logic [KindW-1:0] KindEnd     = 3'd4;
  localparam logic [KindW-1:0] KindIgnored = 3'd5;

  localparam logic [CfgIdxW-1:0] RegOriginX  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegOriginY  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegAreaW    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegAreaH    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegScreenW  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegScreenH  = 3'd5;
  localparam logic [CfgIdxW-1:0] RegVertical = 3'd6;

  localparam logic [ScrW-1:0] ScreenWReset = 13'd320;
  localparam logic [ScrW-1:0] ScreenHReset = 13'd240;

  typedef enum logic [2:0] {
    ClsEnd,
    ClsLf,
    ClsCr,
    ClsMissing,
    ClsGlyph
  } cls_t;

  typedef struct packed {
    cls_t             cls;
    logic [SizeW-1:0] gw;
    logic [SizeW-1:0] gh;
    logic [SizeW-1:0] msz;
    logic [SizeW-1:0] csz;
  } fe_item_t;

  typedef struct packed {
    logic [OrgW-1:0] origin_x;
    logic [OrgW-1:0] origin_y;
    logic [OrgW-1:0] area_w;
    logic [OrgW-1:0] area_h;
    logic [ScrW-1:0] screen_w;
    logic [ScrW-1:0] screen_h;
    logic            vert;
  } cfg_t;

  typedef struct packed {
    logic                 en;
    logic [CoordBits-1:0] x;
    logic [CoordBits-1:0] y;
  } home_t;

  function automatic logic [CoordBits-1:0] sat(input logic [CmpW-1:0] v);
    logic [CmpW-1:0] lim;
    lim = CmpW'({CoordBits{1'b1}});
    return (v > lim) ? {CoordBits{1'b1}} : v[CoordBits-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== design/tlc_in_if.sv =====
`default_nettype none
interface tlc_in_if;
  import tlc_pkg::*;
  logic             valid;
  logic             ready;
  logic [CodeW-1:0] char_code;
  logic             glyph_found;
  logic [SizeW-1:0] glyph_width;
  logic [SizeW-1:0] glyph_height;
  modport source (output valid, char_code, glyph_found, glyph_width, glyph_height,
                  input ready);
  modport sink (input valid, char_code, glyph_found, glyph_width, glyph_height,
                output ready);
endinterface
`default_nettype wire

// ===== design/tlc_out_if.sv =====
`default_nettype none
interface tlc_out_if;
  import tlc_pkg::*;
  logic             valid;
  logic             ready;
  logic [KindW-1:0] kind;
  logic [PosW-1:0]  pos_x;
  logic [PosW-1:0]  pos_y;
  logic [SizeW-1:0] box_width;
  logic [SizeW-1:0] box_height;
  modport source (output valid, kind, pos_x, pos_y, box_width, box_height,
                  input ready);
  modport sink (input valid, kind, pos_x, pos_y, box_width, box_height,
                output ready);
endinterface
`default_nettype wire

// ===== design/tlc_cfg_if.sv =====
`default_nettype none
interface tlc_cfg_if;
  import tlc_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== design/text_layout_cursor_unit.sv =====
`default_nettype none
// Text layout cursor: places one decoded character per item and returns one
// result item per character (place glyph, missing-glyph box, control, clipped
// stop, end of string or ignored). Sustained rate is one item per clock while
// the receiver keeps out_ch ready; an item passes the front classify register,
// a two-entry queue and the back cursor update with its output register. The
// back stage's cursor add/compare chain is combinational. Configuration
// writes are taken every cycle; writing origin_x or origin_y returns the
// cursor to the origin and clears the stop flag. Write configuration only
// when no item is in flight.
module text_layout_cursor_unit (
  input  logic      clk,
  input  logic      rst_n,
  tlc_in_if.sink    in_ch,
  tlc_out_if.source out_ch,
  tlc_cfg_if.sink   cfg_ch
);
  import tlc_pkg::*;

  logic [OrgW-1:0] origin_x_r, origin_y_r, area_w_r, area_h_r;
  logic [ScrW-1:0] screen_w_r, screen_h_r;
  logic            vert_r;
  logic            cfg_take;
  logic [OrgW-1:0] new_ox, new_oy;
  cfg_t            cfg;
  home_t           home;
  fe_item_t        fe_item, q_item;
  logic            fe_valid, fe_ready, q_valid, q_ready;

  assign cfg_ch.ready = 1'b1;
  assign cfg_take     = cfg_ch.valid && cfg_ch.ready;

  assign new_ox = (cfg_ch.index == RegOriginX) ? cfg_ch.data[OrgW-1:0] : origin_x_r;
  assign new_oy = (cfg_ch.index == RegOriginY) ? cfg_ch.data[OrgW-1:0] : origin_y_r;

  assign home.en = cfg_take &&
                   (cfg_ch.index == RegOriginX || cfg_ch.index == RegOriginY);
  assign home.x  = sat(CmpW'(new_ox));
  assign home.y  = sat(CmpW'(new_oy));

  assign cfg.origin_x = origin_x_r;
  assign cfg.origin_y = origin_y_r;
  assign cfg.area_w   = area_w_r;
  assign cfg.area_h   = area_h_r;
  assign cfg.screen_w = screen_w_r;
  assign cfg.screen_h = screen_h_r;
  assign cfg.vert     = vert_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
      area_w_r   <= '0;
      area_h_r   <= '0;
      screen_w_r <= ScreenWReset;
      screen_h_r <= ScreenHReset;
      vert_r     <= 1'b0;
    end else if (cfg_take) begin
      unique case (cfg_ch.index)
        RegOriginX:  origin_x_r <= cfg_ch.data[OrgW-1:0];
        RegOriginY:  origin_y_r <= cfg_ch.data[OrgW-1:0];
        RegAreaW:    area_w_r   <= cfg_ch.data[OrgW-1:0];
        RegAreaH:    area_h_r   <= cfg_ch.data[OrgW-1:0];
        RegScreenW:  screen_w_r <= cfg_ch.data[ScrW-1:0];
        RegScreenH:  screen_h_r <= cfg_ch.data[ScrW-1:0];
        RegVertical: vert_r     <= cfg_ch.data[0];
        default: begin
        end
      endcase
    end
  end

  tlc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg        (cfg),
    .item       (fe_item),
    .item_valid (fe_valid),
    .item_ready (fe_ready)
  );

  tlc_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_item  (fe_item),
    .push_valid (fe_valid),
    .push_ready (fe_ready),
    .pop_item   (q_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready)
  );

  tlc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .home       (home),
    .item       (q_item),
    .item_valid (q_valid),
    .item_ready (q_ready),
    .out_ch     (out_ch)
  );

endmodule
`default_nettype wire

// ===== design/tlc_front.sv =====
`default_nettype none
module tlc_front (
  input  logic              clk,
  input  logic              rst_n,
  tlc_in_if.sink            in_ch,
  input  tlc_pkg::cfg_t     cfg,
  output tlc_pkg::fe_item_t item,
  output logic              item_valid,
  input  logic              item_ready
);
  import tlc_pkg::*;

  logic     valid_r;
  fe_item_t item_r;
  fe_item_t item_nxt;
  logic     take;

  assign in_ch.ready = !valid_r || item_ready;
  assign take        = in_ch.valid && in_ch.ready;
  assign item        = item_r;
  assign item_valid  = valid_r;

  always_comb begin
    item_nxt.gw  = in_ch.glyph_width;
    item_nxt.gh  = in_ch.glyph_height;
    item_nxt.msz = cfg.vert ? in_ch.glyph_height : in_ch.glyph_width;
    item_nxt.csz = cfg.vert ? in_ch.glyph_width : in_ch.glyph_height;
    priority if (in_ch.char_code == ChEnd) begin
      item_nxt.cls = ClsEnd;
    end else if (in_ch.char_code == ChLf) begin
      item_nxt.cls = ClsLf;
    end else if (in_ch.char_code == ChCr) begin
      item_nxt.cls = ClsCr;
    end else if (!in_ch.glyph_found) begin
      item_nxt.cls = ClsMissing;
    end else begin
      item_nxt.cls = ClsGlyph;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= 1'b1;
    end else if (item_ready) begin
      valid_r <= 1'b0;
    end
    if (take) begin
      item_r <= item_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== design/tlc_fifo.sv =====
`default_nettype none
module tlc_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  tlc_pkg::fe_item_t push_item,
  input  logic              push_valid,
  output logic              push_ready,
  output tlc_pkg::fe_item_t pop_item,
  output logic              pop_valid,
  input  logic              pop_ready
);
  import tlc_pkg::*;

  fe_item_t   mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       push;
  logic       pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

// ===== design/tlc_back.sv =====
`default_nettype none
module tlc_back (
  input  logic              clk,
  input  logic              rst_n,
  input  tlc_pkg::cfg_t     cfg,
  input  tlc_pkg::home_t    home,
  input  tlc_pkg::fe_item_t item,
  input  logic              item_valid,
  output logic              item_ready,
  tlc_out_if.source         out_ch
);
  import tlc_pkg::*;

  logic [CoordBits-1:0] cx_r, cy_r;
  logic [SizeW-1:0]     le_r;
  logic                 stop_r;
  logic                 ov_r;
  logic [KindW-1:0]     kind_r;
  logic [PosW-1:0]      px_r, py_r;
  logic [SizeW-1:0]     bw_r, bh_r;

  logic [CoordBits-1:0] cx_nxt, cy_nxt;
  logic [SizeW-1:0]     le_nxt;
  logic                 stop_nxt;
  logic [KindW-1:0]     kind_nxt;
  logic [PosW-1:0]      px_nxt, py_nxt;
  logic [SizeW-1:0]     bw_nxt, bh_nxt;

  logic                 take;
  logic [EndW-1:0]      end_x, end_y, mend, cend;
  logic [CoordBits-1:0] mpos, cpos, morg, corg;
  logic [CoordBits-1:0] m_n, c_n, rm, rc, m1, c1, cext, madv;
  logic [SizeW-1:0]     le1;
  logic                 wrap, clip;

  assign item_ready = !ov_r || out_ch.ready;
  assign take       = item_valid && item_ready;

  assign out_ch.valid      = ov_r;
  assign out_ch.kind       = kind_r;
  assign out_ch.pos_x      = px_r;
  assign out_ch.pos_y      = py_r;
  assign out_ch.box_width  = bw_r;
  assign out_ch.box_height = bh_r;

  always_comb begin
    end_x = (cfg.area_w != '0) ? EndW'(cfg.origin_x) + EndW'(cfg.area_w) : cfg.screen_w;
    end_y = (cfg.area_h != '0) ? EndW'(cfg.origin_y) + EndW'(cfg.area_h) : cfg.screen_h;
    mpos  = cfg.vert ? cy_r : cx_r;
    cpos  = cfg.vert ? cx_r : cy_r;
    morg  = sat(CmpW'(cfg.vert ? cfg.origin_y : cfg.origin_x));
    corg  = sat(CmpW'(cfg.vert ? cfg.origin_x : cfg.origin_y));
    mend  = cfg.vert ? end_y : end_x;
    cend  = cfg.vert ? end_x : end_y;

    cext = sat(CmpW'(cpos) + CmpW'(le_r));
    wrap = (CmpW'(mpos) + CmpW'(item.msz)) > CmpW'(mend);
    m1   = wrap ? morg : mpos;
    c1   = wrap ? cext : cpos;
    le1  = wrap ? '0 : le_r;
    clip = (CmpW'(c1) + CmpW'(item.csz)) > CmpW'(cend);
    madv = sat(CmpW'(m1) + CmpW'(item.msz));

    m_n      = mpos;
    c_n      = cpos;
    le_nxt   = le_r;
    stop_nxt = stop_r;
    kind_nxt = KindIgnored;
    rm       = mpos;
    rc       = cpos;
    bw_nxt   = '0;
    bh_nxt   = '0;

    priority if (item.cls == ClsEnd) begin
      m_n      = morg;
      c_n      = corg;
      le_nxt   = '0;
      stop_nxt = 1'b0;
      kind_nxt = KindEnd;
      rm       = morg;
      rc       = corg;
    end else if (stop_r) begin
      kind_nxt = KindIgnored;
    end else begin
      unique case (item.cls)
        ClsLf: begin
          c_n      = cext;
          le_nxt   = '0;
          kind_nxt = KindControl;
          rc       = cext;
        end
        ClsCr: begin
          m_n      = morg;
          kind_nxt = KindControl;
          rm       = morg;
        end
        ClsMissing: begin
          kind_nxt = KindInvalid;
          bw_nxt   = BadBox;
          bh_nxt   = BadBox;
        end
        ClsGlyph: begin
          rm     = m1;
          rc     = c1;
          bw_nxt = item.gw;
          bh_nxt = item.gh;
          c_n    = c1;
          if (clip) begin
            m_n      = m1;
            le_nxt   = le1;
            stop_nxt = 1'b1;
            kind_nxt = KindClipped;
          end else begin
            m_n      = madv;
            le_nxt   = (le1 < item.csz) ? item.csz : le1;
            kind_nxt = KindPlace;
          end
        end
        default: begin
          kind_nxt = KindIgnored;
        end
      endcase
    end

    cx_nxt = cfg.vert ? c_n : m_n;
    cy_nxt = cfg.vert ? m_n : c_n;
    px_nxt = PosW'(cfg.vert ? rc : rm);
    py_nxt = PosW'(cfg.vert ? rm : rc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r   <= '0;
      cy_r   <= '0;
      le_r   <= '0;
      stop_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      if (home.en) begin
        cx_r   <= home.x;
        cy_r   <= home.y;
        le_r   <= '0;
        stop_r <= 1'b0;
      end else if (take) begin
        cx_r   <= cx_nxt;
        cy_r   <= cy_nxt;
        le_r   <= le_nxt;
        stop_r <= stop_nxt;
      end
      if (take) begin
        ov_r <= 1'b1;
      end else if (out_ch.ready) begin
        ov_r <= 1'b0;
      end
    end
    if (take) begin
      kind_r <= kind_nxt;
      px_r   <= px_nxt;
      py_r   <= py_nxt;
      bw_r   <= bw_nxt;
      bh_r   <= bh_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tlc_pkg::*;

  localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;
  localparam int StallLimit = 4000;
  localparam int DrainCycles = 12;
  localparam int MaxReports = 10;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [PosW-1:0]  x;
    logic [PosW-1:0]  y;
    logic [SizeW-1:0] w;
    logic [SizeW-1:0] h;
  } placement_t;

  logic clk = 1'b0;
  logic rst_n;

  tlc_in_if  in_ch();
  tlc_out_if out_ch();
  tlc_cfg_if cfg_ch();

  text_layout_cursor_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // layout state mirror
  int unsigned org_x, org_y, area_w, area_h, scr_w, scr_h;
  logic        vert;
  int unsigned cur_x, cur_y, line_ext;
  logic        stopped;

  placement_t placements_due[$];
  int fail_count = 0;
  int idle_cycles = 0;

  logic tx_idle_en = 1'b0;
  int   tx_burst_left = 0;
  logic rx_stall_en = 1'b0;
  logic rx_on = 1'b1;
  int   rx_left = 0;

  function automatic int unsigned clamp_coord(input int unsigned v);
    int unsigned lim;
    lim = (1 << CoordBits) - 1;
    return (v > lim) ? lim : v;
  endfunction

  function automatic void home_cursor();
    cur_x = clamp_coord(org_x);
    cur_y = clamp_coord(org_y);
    line_ext = 0;
    stopped = 1'b0;
  endfunction

  function automatic void set_axes(input int unsigned m, input int unsigned c);
    if (vert) begin
      cur_y = m;
      cur_x = c;
    end else begin
      cur_x = m;
      cur_y = c;
    end
  endfunction

  function automatic void reset_layout();
    org_x = 0;
    org_y = 0;
    area_w = 0;
    area_h = 0;
    scr_w = ScreenWReset;
    scr_h = ScreenHReset;
    vert = 1'b0;
    home_cursor();
  endfunction

  function automatic void apply_reg(input logic [CfgIdxW-1:0] idx,
                                    input logic [CfgDataW-1:0] value);
    case (idx)
      RegOriginX: begin
        org_x = value & 13'hFFF;
        home_cursor();
      end
      RegOriginY: begin
        org_y = value & 13'hFFF;
        home_cursor();
      end
      RegAreaW:    area_w = value & 13'hFFF;
      RegAreaH:    area_h = value & 13'hFFF;
      RegScreenW:  scr_w = value;
      RegScreenH:  scr_h = value;
      RegVertical: vert = value[0];
      default: ;
    endcase
  endfunction

  function automatic placement_t layout_char(input logic [CodeW-1:0] code,
                                             input logic found,
                                             input logic [SizeW-1:0] gw,
                                             input logic [SizeW-1:0] gh);
    placement_t r;
    int unsigned end_x, end_y, m, c, morg, mend, cend, msz, csz;
    end_x = (area_w != 0) ? org_x + area_w : scr_w;
    end_y = (area_h != 0) ? org_y + area_h : scr_h;
    m = vert ? cur_y : cur_x;
    c = vert ? cur_x : cur_y;
    morg = clamp_coord(vert ? org_y : org_x);
    mend = vert ? end_y : end_x;
    cend = vert ? end_x : end_y;
    msz = vert ? gh : gw;
    csz = vert ? gw : gh;
    r = '0;
    if (code == ChEnd) begin
      home_cursor();
      r.kind = KindEnd;
    end else if (stopped) begin
      r.kind = KindIgnored;
    end else if (code == ChLf) begin
      c = clamp_coord(c + line_ext);
      line_ext = 0;
      set_axes(m, c);
      r.kind = KindControl;
    end else if (code == ChCr) begin
      set_axes(morg, c);
      r.kind = KindControl;
    end else if (!found) begin
      r.kind = KindInvalid;
      r.w = BadBox;
      r.h = BadBox;
    end else begin
      if (m + msz > mend) begin
        m = morg;
        c = clamp_coord(c + line_ext);
        line_ext = 0;
      end
      set_axes(m, c);
      r.w = gw;
      r.h = gh;
      if (c + csz > cend) begin
        stopped = 1'b1;
        r.kind = KindClipped;
      end else begin
        if (line_ext < csz) line_ext = csz;
        r.kind = KindPlace;
      end
    end
    r.x = PosW'(cur_x);
    r.y = PosW'(cur_y);
    if (r.kind == KindPlace) set_axes(clamp_coord(m + msz), c);
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    placement_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.kind, out_ch.pos_x, out_ch.pos_y, out_ch.box_width,
              out_ch.box_height};
      if (placements_due.size() == 0) begin
        fail_count++;
        if (fail_count <= MaxReports)
          $display("unexpected item: kind %0d pos (%0d,%0d) box %0dx%0d",
                   got.kind, got.x, got.y, got.w, got.h);
      end else begin
        want = placements_due.pop_front();
        if (got.kind !== want.kind || got.x !== want.x || got.y !== want.y ||
            got.w !== want.w || got.h !== want.h) begin
          fail_count++;
          if (fail_count <= MaxReports)
            $display("mismatch: exp kind %0d pos (%0d,%0d) box %0dx%0d, got kind %0d pos (%0d,%0d) box %0dx%0d",
                     want.kind, want.x, want.y, want.w, want.h,
                     got.kind, got.x, got.y, got.w, got.h);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || !rst_n) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // receiver stall pattern
  always @(negedge clk) begin
    if (!rx_stall_en) begin
      out_ch.ready = 1'b1;
    end else begin
      if (rx_left == 0) begin
        rx_on = !rx_on;
        rx_left = rx_on ? $urandom_range(1, 9) : $urandom_range(1, 6);
      end
      rx_left--;
      out_ch.ready = rx_on;
    end
  end

  task automatic send_char(input logic [CodeW-1:0] code, input logic found,
                           input logic [SizeW-1:0] gw, input logic [SizeW-1:0] gh);
    int gap;
    in_ch.valid = 1'b1;
    in_ch.char_code = code;
    in_ch.glyph_found = found;
    in_ch.glyph_width = gw;
    in_ch.glyph_height = gh;
    do @(posedge clk); while (!in_ch.ready);
    placements_due.push_back(layout_char(code, found, gw, gh));
    @(negedge clk);
    if (tx_idle_en) begin
      if (tx_burst_left > 0) tx_burst_left--;
      if (tx_burst_left == 0) begin
        gap = $urandom_range(1, 6);
        in_ch.valid = 1'b0;
        repeat (gap) @(negedge clk);
        tx_burst_left = $urandom_range(1, 12);
      end
    end
  endtask

  task automatic wait_idle();
    in_ch.valid = 1'b0;
    while (placements_due.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int unsigned value);
    wait_idle();
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data = CfgDataW'(value);
    do @(posedge clk); while (!cfg_ch.ready);
    apply_reg(idx, CfgDataW'(value));
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  function automatic logic [SizeW-1:0] pick_extent(input int lo, input int hi);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return SizeW'($urandom_range(0, 255));
      default: return SizeW'($urandom_range(lo, hi));
    endcase
  endfunction

  task automatic test_horizontal_flow();
    tx_idle_en = 1'b1;
    rx_stall_en = 1'b1;
    send_char("A", 1'b1, 8'd8, 8'd16);
    send_char(16'hFFFF, 1'b1, 8'd255, 8'd0);
    send_char("B", 1'b0, 8'd255, 8'd255);   // missing glyph
    send_char("C", 1'b1, 8'd100, 8'd8);     // wraps
    send_char(ChLf, 1'b1, 8'd7, 8'd7);
    send_char(ChCr, 1'b0, 8'd255, 8'd255);
    send_char("D", 1'b1, 8'd0, 8'd255);     // clips
    send_char("E", 1'b1, 8'd4, 8'd4);       // ignored
    send_char(ChLf, 1'b1, 8'd0, 8'd0);      // ignored
    send_char(ChEnd, 1'b1, 8'd255, 8'd255);
    send_char("F", 1'b1, 8'd16, 8'd240);    // exact fit
    send_char(ChLf, 1'b0, 8'd0, 8'd0);
    send_char(ChEnd, 1'b0, 8'd0, 8'd0);
  endtask

  task automatic test_vertical_extremes();
    write_reg(RegVertical, 1);
    write_reg(RegAreaW, 4095);
    write_reg(RegAreaH, 4095);
    write_reg(RegOriginX, 13'h1FFF);
    write_reg(RegOriginY, 4095);
    write_reg(RegUnused, 13'h1FFF);
    send_char("G", 1'b1, 8'd255, 8'd255);
    send_char(ChCr, 1'b1, 8'd1, 8'd1);
    send_char(ChLf, 1'b1, 8'd1, 8'd1);
    send_char("H", 1'b1, 8'd8, 8'd255);
    send_char(ChEnd, 1'b1, 8'd0, 8'd0);
    write_reg(RegAreaW, 0);
    write_reg(RegAreaH, 0);
    write_reg(RegScreenW, 0);
    write_reg(RegScreenH, 0);
    write_reg(RegOriginX, 0);
    write_reg(RegOriginY, 0);
    send_char("I", 1'b1, 8'd0, 8'd0);       // zero size fits a zero screen
    send_char("J", 1'b1, 8'd1, 8'd1);       // wraps then clips
    send_char(ChEnd, 1'b1, 8'd0, 8'd0);
    write_reg(RegVertical, 0);
    write_reg(RegScreenW, 4096);
    write_reg(RegScreenH, 13'h1FFF);
    send_char("K", 1'b1, 8'd255, 8'd255);
    send_char("L", 1'b1, 8'd128, 8'd1);
    send_char(ChEnd, 1'b1, 8'd0, 8'd0);
  endtask

  task automatic randomize_layout();
    int unsigned v[7];
    for (int i = 0; i < 2; i++)
      case ($urandom_range(0, 3))
        0: v[i] = 0;
        1: v[i] = $urandom_range(0, 200);
        2: v[i] = $urandom_range(0, 4095);
        default: v[i] = $urandom_range(0, 8191);
      endcase
    for (int i = 2; i < 4; i++)
      case ($urandom_range(0, 5))
        0, 1: v[i] = 0;
        2, 3: v[i] = $urandom_range(8, 400);
        4: v[i] = $urandom_range(0, 8191);
        default: v[i] = 4095;
      endcase
    for (int i = 4; i < 6; i++)
      case ($urandom_range(0, 7))
        0: v[i] = 0;
        1: v[i] = 4096;
        2: v[i] = 8191;
        3, 4: v[i] = $urandom_range(1, 4096);
        default: v[i] = (i == 4) ? ScreenWReset : ScreenHReset;
      endcase
    v[6] = $urandom_range(0, 8191);
    write_reg(RegAreaW, v[2]);
    write_reg(RegAreaH, v[3]);
    write_reg(RegScreenW, v[4]);
    write_reg(RegScreenH, v[5]);
    write_reg(RegVertical, v[6]);
    if ($urandom_range(0, 7) == 0) write_reg(RegUnused, $urandom_range(0, 8191));
    write_reg(RegOriginX, v[0]);
    write_reg(RegOriginY, v[1]);
  endtask

  task automatic test_random_text(input int phases, input int items_per_phase);
    int sent, len, pick, mode;
    for (int p = 0; p < phases; p++) begin
      randomize_layout();
      mode = $urandom_range(0, 5);
      tx_idle_en = (mode != 0 && mode != 1);
      rx_stall_en = (mode != 0 && mode != 2);
      sent = 0;
      while (sent < items_per_phase) begin
        len = $urandom_range(1, 30);
        for (int k = 0; k < len; k++) begin
          pick = $urandom_range(0, 99);
          if (pick < 75)
            send_char(CodeW'($urandom_range(32, 126)), 1'b1,
                      pick_extent(1, 24), pick_extent(4, 32));
          else if (pick < 83)
            send_char(CodeW'($urandom_range(32, 126)), 1'b0,
                      SizeW'($urandom), SizeW'($urandom));
          else if (pick < 89)
            send_char(ChLf, 1'($urandom), SizeW'($urandom), SizeW'($urandom));
          else if (pick < 93)
            send_char(ChCr, 1'($urandom), SizeW'($urandom), SizeW'($urandom));
          else
            send_char(CodeW'($urandom), 1'($urandom), SizeW'($urandom),
                      SizeW'($urandom));
          sent++;
        end
        if ($urandom_range(0, 9) != 0) begin
          send_char(ChEnd, 1'($urandom), SizeW'($urandom), SizeW'($urandom));
          sent++;
        end
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.char_code = '0;
    in_ch.glyph_found = 1'b0;
    in_ch.glyph_width = '0;
    in_ch.glyph_height = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    out_ch.ready = 1'b1;
    reset_layout();
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    test_horizontal_flow();
    test_vertical_extremes();
    test_random_text(10, 110);

    wait_idle();
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
design/tlc_pkg.sv
design/tlc_in_if.sv
design/tlc_out_if.sv
design/tlc_cfg_if.sv
design/tlc_front.sv
design/tlc_fifo.sv
design/tlc_back.sv
design/text_layout_cursor_unit.sv
tb/tb.sv
